/* rtl/core/uart_register_file_with_fifos_unit_defines.svh */
// Assertion macros for the UART register file block.
// Included by every RTL file that carries concurrent assertions.
`ifndef UART_REGISTER_FILE_WITH_FIFOS_UNIT_DEFINES_SVH
`define UART_REGISTER_FILE_WITH_FIFOS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge while reset is released.
`define URF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("URF assertion failed");
// Property checked on every rising edge, also while reset is held.
`define URF_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("URF assertion failed");
`else
`define URF_ASSERT(name, clk, rst_n, prop)
`define URF_ASSERT_NR(name, clk, prop)
`endif

`endif

/* rtl/core/urf_pkg.sv */
// Shared types, register codes and helper functions for the UART register file.
// No dependencies; used by every module of the block except urf_ram.
`default_nettype none

package urf_pkg;

  // Default sizes.
  localparam int FIFO_DEPTH = 16;
  localparam int CMDQ_DEPTH = 4;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RX_BYTE = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // Register offsets.
  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_IER     = 3'd1;
  localparam logic [2:0] REG_IIR_FCR = 3'd2;
  localparam logic [2:0] REG_LCR     = 3'd3;
  localparam logic [2:0] REG_MCR     = 3'd4;
  localparam logic [2:0] REG_LSR     = 3'd5;
  localparam logic [2:0] REG_MSR     = 3'd6;
  localparam logic [2:0] REG_SCR     = 3'd7;

  // Fixed read values and interrupt identification codes.
  localparam logic [7:0] IIR_RX_DATA  = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY = 8'h02;
  localparam logic [7:0] IIR_NONE     = 8'h01;
  localparam logic [7:0] MSR_VALUE    = 8'hb0;
  localparam logic [7:0] MCR_VALUE    = 8'h08;

  // Bit positions inside FCR, IER and LCR.
  localparam int FCR_RX_CLR = 1;
  localparam int FCR_TX_CLR = 2;
  localparam int FCR_DMA    = 3;
  localparam int IER_RX     = 0;
  localparam int IER_TX     = 1;
  localparam int LCR_DLAB   = 7;

  // Decoded commands handed from the front to the back.
  typedef enum logic [3:0] {
    CMD_RX_POP,
    CMD_RD_IER,
    CMD_RD_IIR,
    CMD_RD_LCR,
    CMD_RD_FIXED,
    CMD_RD_LSR,
    CMD_RD_SCR,
    CMD_TX_PUSH,
    CMD_WR_IER,
    CMD_WR_FCR,
    CMD_WR_LCR,
    CMD_WR_IGNORED,
    CMD_WR_SCR,
    CMD_WR_BAD,
    CMD_RX_PUSH,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  // Channel payloads.
  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_address;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       irq;
    logic       access_error;
    logic       last;
  } out_item_t;

  // Interrupt line from the FIFO levels, the enables and the transmit acknowledge.
  function automatic logic irq_calc(input logic rx_not_empty, input logic tx_empty,
                                    input logic rx_ie, input logic tx_ie,
                                    input logic tx_acked);
    logic result;
    result = (rx_ie & rx_not_empty) | (tx_ie & tx_empty & ~tx_acked);
    return result;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/urf_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No package dependency.
`default_nettype none

module urf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write and registered read; read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/urf_front.sv */
// Front end: classifies an incoming item into a register command.
// Depends on urf_pkg.
`default_nettype none

module urf_front (
  input  wire logic             in_valid_i,
  input  wire urf_pkg::in_item_t in_item_i,
  input  wire logic             q_full_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output urf_pkg::cmd_t         cmd_o
);

  // Accept whenever the command queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  // Decode operation and register offset into a command.
  always_comb begin
    cmd_o.kind = urf_pkg::CMD_TICK;
    cmd_o.data = in_item_i.data_byte;
    case (urf_pkg::op_e'(in_item_i.operation))
      urf_pkg::OP_READ: begin
        case (in_item_i.reg_address)
          urf_pkg::REG_DATA:    cmd_o.kind = urf_pkg::CMD_RX_POP;
          urf_pkg::REG_IER:     cmd_o.kind = urf_pkg::CMD_RD_IER;
          urf_pkg::REG_IIR_FCR: cmd_o.kind = urf_pkg::CMD_RD_IIR;
          urf_pkg::REG_LCR:     cmd_o.kind = urf_pkg::CMD_RD_LCR;
          urf_pkg::REG_MCR: begin
            cmd_o.kind = urf_pkg::CMD_RD_FIXED;
            cmd_o.data = urf_pkg::MCR_VALUE;
          end
          urf_pkg::REG_LSR:     cmd_o.kind = urf_pkg::CMD_RD_LSR;
          urf_pkg::REG_MSR: begin
            cmd_o.kind = urf_pkg::CMD_RD_FIXED;
            cmd_o.data = urf_pkg::MSR_VALUE;
          end
          urf_pkg::REG_SCR:     cmd_o.kind = urf_pkg::CMD_RD_SCR;
          default:              cmd_o.kind = urf_pkg::CMD_RD_SCR;
        endcase
      end
      urf_pkg::OP_WRITE: begin
        case (in_item_i.reg_address)
          urf_pkg::REG_DATA:    cmd_o.kind = urf_pkg::CMD_TX_PUSH;
          urf_pkg::REG_IER:     cmd_o.kind = urf_pkg::CMD_WR_IER;
          urf_pkg::REG_IIR_FCR: cmd_o.kind = urf_pkg::CMD_WR_FCR;
          urf_pkg::REG_LCR:     cmd_o.kind = urf_pkg::CMD_WR_LCR;
          urf_pkg::REG_MCR:     cmd_o.kind = urf_pkg::CMD_WR_IGNORED;
          urf_pkg::REG_SCR:     cmd_o.kind = urf_pkg::CMD_WR_SCR;
          default:              cmd_o.kind = urf_pkg::CMD_WR_BAD;
        endcase
      end
      urf_pkg::OP_RX_BYTE: cmd_o.kind = urf_pkg::CMD_RX_PUSH;
      urf_pkg::OP_TICK:    cmd_o.kind = urf_pkg::CMD_TICK;
      default:             cmd_o.kind = urf_pkg::CMD_TICK;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/urf_cmd_queue.sv */
// Short command queue between the front end and the back end.
// Depends on urf_pkg for the command type and the queue depth.
`default_nettype none

module urf_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire urf_pkg::cmd_t cmd_i,
  output logic               full_o,
  output logic               valid_o,
  output urf_pkg::cmd_t      cmd_o,
  input  wire logic          pop_i
);

  localparam int Depth = urf_pkg::CMDQ_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  urf_pkg::cmd_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/urf_back.sv */
// Back end: executes register commands, owns the FIFOs and the output register.
// Depends on urf_pkg, urf_ram and the assertion macro header.
`default_nettype none
`include "uart_register_file_with_fifos_unit_defines.svh"

module urf_back #(
  parameter int FifoDepth = urf_pkg::FIFO_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire urf_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  output urf_pkg::out_item_t out_item_o,
  input  wire logic          out_stall_i
);

  localparam int PtrW = $clog2(FifoDepth);
  localparam int CntW = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DRAIN
  } state_e;

  state_e             state_q, state_d;
  logic [PtrW-1:0]    tx_head_q, tx_head_d, rx_head_q, rx_head_d;
  logic [CntW-1:0]    tx_count_q, tx_count_d, rx_count_q, rx_count_d;
  logic               rx_ie_q, rx_ie_d, tx_ie_q, tx_ie_d;
  logic               tx_acked_q, tx_acked_d;
  logic [7:0]         lcr_q, lcr_d, scratch_q, scratch_d;
  logic               out_valid_q, out_valid_d;
  urf_pkg::out_item_t out_q, out_d;

  logic            tx_we, tx_re, rx_we, rx_re;
  logic [PtrW-1:0] tx_waddr, rx_waddr;
  logic [7:0]      tx_rdata, rx_rdata;
  logic [CntW:0]   tx_sum, rx_sum;
  logic [PtrW-1:0] tx_head_inc, rx_head_inc;
  logic            can_load, dlab, tx_full, rx_full;
  logic            rx_cause, tx_cause, emit, err;
  logic [7:0]      rd;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign can_load    = ~out_valid_q | ~out_stall_i;
  assign dlab        = lcr_q[urf_pkg::LCR_DLAB];
  assign tx_full     = (tx_count_q == CntW'(FifoDepth));
  assign rx_full     = (rx_count_q == CntW'(FifoDepth));
  assign rx_cause    = rx_ie_q & (rx_count_q != '0);
  assign tx_cause    = tx_ie_q & (tx_count_q == '0) & ~tx_acked_q;

  // Tail positions and next head positions, wrapping at the FIFO depth.
  assign tx_sum   = (CntW+1)'(tx_head_q) + (CntW+1)'(tx_count_q);
  assign rx_sum   = (CntW+1)'(rx_head_q) + (CntW+1)'(rx_count_q);
  assign tx_waddr = (tx_sum >= (CntW+1)'(FifoDepth)) ?
                    PtrW'(tx_sum - (CntW+1)'(FifoDepth)) : PtrW'(tx_sum);
  assign rx_waddr = (rx_sum >= (CntW+1)'(FifoDepth)) ?
                    PtrW'(rx_sum - (CntW+1)'(FifoDepth)) : PtrW'(rx_sum);
  assign tx_head_inc = (tx_head_q == PtrW'(FifoDepth - 1)) ? '0 : tx_head_q + 1'b1;
  assign rx_head_inc = (rx_head_q == PtrW'(FifoDepth - 1)) ? '0 : rx_head_q + 1'b1;

  // Character stores.
  urf_ram #(.Width(8), .Depth(FifoDepth)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (cmd_i.data),
    .re_i    (tx_re),
    .raddr_i (tx_head_q),
    .rdata_o (tx_rdata)
  );

  urf_ram #(.Width(8), .Depth(FifoDepth)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (cmd_i.data),
    .re_i    (rx_re),
    .raddr_i (rx_head_q),
    .rdata_o (rx_rdata)
  );

  // Command execution and result generation.
  always_comb begin
    state_d     = state_q;
    tx_head_d   = tx_head_q;
    tx_count_d  = tx_count_q;
    rx_head_d   = rx_head_q;
    rx_count_d  = rx_count_q;
    rx_ie_d     = rx_ie_q;
    tx_ie_d     = tx_ie_q;
    tx_acked_d  = tx_acked_q;
    lcr_d       = lcr_q;
    scratch_d   = scratch_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    cmd_pop_o   = 1'b0;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    emit        = 1'b0;
    err         = 1'b0;
    rd          = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && can_load) begin
          cmd_pop_o = 1'b1;
          emit      = 1'b1;
          case (cmd_i.kind)
            urf_pkg::CMD_RX_POP: begin
              if (!dlab && rx_count_q != '0) begin
                rx_re      = 1'b1;
                rx_head_d  = rx_head_inc;
                rx_count_d = rx_count_q - 1'b1;
                state_d    = ST_POP;
                emit       = 1'b0;
              end
            end
            urf_pkg::CMD_RD_IER: begin
              if (!dlab) begin
                rd[urf_pkg::IER_RX] = rx_ie_q;
                rd[urf_pkg::IER_TX] = tx_ie_q;
              end
            end
            urf_pkg::CMD_RD_IIR: begin
              if (rx_cause) begin
                rd = urf_pkg::IIR_RX_DATA;
              end else if (tx_cause) begin
                rd         = urf_pkg::IIR_TX_EMPTY;
                tx_acked_d = 1'b1;
              end else begin
                rd = urf_pkg::IIR_NONE;
              end
            end
            urf_pkg::CMD_RD_LCR:   rd = lcr_q;
            urf_pkg::CMD_RD_FIXED: rd = cmd_i.data;
            urf_pkg::CMD_RD_LSR: begin
              rd[0] = (rx_count_q != '0);
              rd[5] = (tx_count_q == '0);
              rd[6] = (tx_count_q == '0);
            end
            urf_pkg::CMD_RD_SCR:   rd = scratch_q;
            urf_pkg::CMD_TX_PUSH: begin
              if (!dlab) begin
                tx_acked_d = 1'b0;
                if (!tx_full) begin
                  tx_we      = 1'b1;
                  tx_count_d = tx_count_q + 1'b1;
                end
              end
            end
            urf_pkg::CMD_WR_IER: begin
              if (!dlab) begin
                rx_ie_d = cmd_i.data[urf_pkg::IER_RX];
                tx_ie_d = cmd_i.data[urf_pkg::IER_TX];
              end
            end
            urf_pkg::CMD_WR_FCR: begin
              if (cmd_i.data[urf_pkg::FCR_DMA]) begin
                err = 1'b1;
              end else begin
                if (cmd_i.data[urf_pkg::FCR_RX_CLR]) begin
                  rx_head_d  = '0;
                  rx_count_d = '0;
                end
                if (cmd_i.data[urf_pkg::FCR_TX_CLR]) begin
                  tx_head_d  = '0;
                  tx_count_d = '0;
                end
              end
            end
            urf_pkg::CMD_WR_LCR:     lcr_d = cmd_i.data;
            urf_pkg::CMD_WR_IGNORED: err = 1'b0;
            urf_pkg::CMD_WR_SCR:     scratch_d = cmd_i.data;
            urf_pkg::CMD_WR_BAD:     err = 1'b1;
            urf_pkg::CMD_RX_PUSH: begin
              if (!rx_full) begin
                rx_we      = 1'b1;
                rx_count_d = rx_count_q + 1'b1;
              end
            end
            urf_pkg::CMD_TICK: begin
              if (tx_full) begin
                tx_re      = 1'b1;
                tx_head_d  = tx_head_inc;
                tx_count_d = tx_count_q - 1'b1;
                state_d    = ST_DRAIN;
                emit       = 1'b0;
              end
            end
            default: err = 1'b0;
          endcase
          if (emit) begin
            out_valid_d        = 1'b1;
            out_d.read_data    = rd;
            out_d.tx_valid     = 1'b0;
            out_d.tx_char      = '0;
            out_d.irq          = urf_pkg::irq_calc(rx_count_d != '0, tx_count_d == '0,
                                                   rx_ie_d, tx_ie_d, tx_acked_d);
            out_d.access_error = err;
            out_d.last         = 1'b1;
          end
        end
      end

      // Receive data read: the popped character arrives from the RAM.
      ST_POP: begin
        if (can_load) begin
          out_valid_d        = 1'b1;
          out_d.read_data    = rx_rdata;
          out_d.tx_valid     = 1'b0;
          out_d.tx_char      = '0;
          out_d.irq          = rx_cause | tx_cause;
          out_d.access_error = 1'b0;
          out_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end

      // Transmit drain: one character per result, the line reflects an empty FIFO.
      ST_DRAIN: begin
        if (can_load) begin
          out_valid_d        = 1'b1;
          out_d.read_data    = '0;
          out_d.tx_valid     = 1'b1;
          out_d.tx_char      = tx_rdata;
          out_d.irq          = urf_pkg::irq_calc(rx_count_q != '0, 1'b1,
                                                 rx_ie_q, tx_ie_q, tx_acked_q);
          out_d.access_error = 1'b0;
          out_d.last         = (tx_count_q == '0);
          if (tx_count_q != '0) begin
            tx_re      = 1'b1;
            tx_head_d  = tx_head_inc;
            tx_count_d = tx_count_q - 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tx_head_q   <= '0;
      tx_count_q  <= '0;
      rx_head_q   <= '0;
      rx_count_q  <= '0;
      rx_ie_q     <= 1'b0;
      tx_ie_q     <= 1'b0;
      tx_acked_q  <= 1'b0;
      lcr_q       <= '0;
      scratch_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      tx_head_q   <= tx_head_d;
      tx_count_q  <= tx_count_d;
      rx_head_q   <= rx_head_d;
      rx_count_q  <= rx_count_d;
      rx_ie_q     <= rx_ie_d;
      tx_ie_q     <= tx_ie_d;
      tx_acked_q  <= tx_acked_d;
      lcr_q       <= lcr_d;
      scratch_q   <= scratch_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // The FIFO levels never pass the depth.
  `URF_ASSERT_NR(a_tx_count_bound, clk_i, tx_count_q <= CntW'(FifoDepth))
  `URF_ASSERT_NR(a_rx_count_bound, clk_i, rx_count_q <= CntW'(FifoDepth))
  // While draining, the first character has already left the transmit FIFO.
  `URF_ASSERT(a_drain_not_full, clk_i, rst_ni,
              (state_q == ST_DRAIN) |-> (tx_count_q < CntW'(FifoDepth)))
  // Only drained characters come as results that are not the last of their item.
  `URF_ASSERT(a_multi_is_tx, clk_i, rst_ni,
              (out_valid_q && !out_q.last) |-> out_q.tx_valid)
  // A tick on a full transmit FIFO starts a drain.
  `URF_ASSERT(a_tick_drains, clk_i, rst_ni,
              (state_q == ST_IDLE && cmd_valid_i && can_load &&
               cmd_i.kind == urf_pkg::CMD_TICK && tx_full) |=> (state_q == ST_DRAIN))

endmodule

`default_nettype wire

/* rtl/core/uart_register_file_with_fifos_unit.sv */
// UART register block (8250 style) with transmit and receive FIFOs.
//
// Input channel (in_valid_i / in_stall_o / in_item_i): bus reads, bus writes,
// arriving receive bytes and update ticks. Items are decoded and queued in a
// four-entry command queue; in_stall_o rises only when that queue is full.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result per item,
// or one result per character when a tick finds the transmit FIFO full.
// The item is written into the command queue and executed from there into the
// result register; a receive data read also passes through the registered read
// of the FIFO RAM before the result register loads.
// One item per cycle while the output is not stalled and no pop or drain is
// running; a receive data read that pops a character waits in the pop state,
// and a draining tick then emits one character per cycle unless stalled.
// Reset: FIFOs empty, all registers zero, no result pending.
// When the receiver stalls, the output register holds its result, execution
// pauses and the command queue fills before the input side stalls.
`default_nettype none

module uart_register_file_with_fifos_unit #(
  parameter int FifoDepth = urf_pkg::FIFO_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire urf_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output urf_pkg::out_item_t      out_item_o
);

  logic          q_full, q_push, q_valid, q_pop;
  urf_pkg::cmd_t front_cmd, queue_cmd;

  // Decode of incoming items.
  urf_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (q_push),
    .cmd_o      (front_cmd)
  );

  // Decoupling queue.
  urf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (queue_cmd),
    .pop_i   (q_pop)
  );

  // Register file, FIFOs and result generation.
  urf_back #(.FifoDepth(FifoDepth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire
